### hw/rtl/spmr_pkg.sv
// Shared constants, types and helper functions of the shuffled minimal-standard generator.
package spmr_pkg;

   // Number of entries in the shuffle table.
   localparam int unsigned TABLE_DEPTH = 32;
   localparam int unsigned WARMUP_EXTRA = 8;
   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned SEED_STEPS = TABLE_DEPTH + WARMUP_EXTRA;
   localparam int unsigned SEED_CNT_W = $clog2(SEED_STEPS);

   // Generator arithmetic.
   localparam logic [30:0] MODULUS = 31'h7FFF_FFFF;
   localparam logic [14:0] MULTIPLIER = 15'd16807;
   localparam logic [30:0] CLAMP_MAX = 31'd2147483389;
   localparam logic [31:0] SEED_RESET = 32'hFFFF_FFFF;

   // Bucket width that maps a 31-bit pick onto a table slot, and its reciprocal.
   localparam longint unsigned BUCKET = 64'd1 + (64'd2147483646 / TABLE_DEPTH);
   localparam int unsigned BUCKET_LOG = $clog2(BUCKET);
   localparam int unsigned RECIP_SHIFT = 31 + BUCKET_LOG;
   localparam longint unsigned RECIP_WIDE = ((64'd1 << RECIP_SHIFT) + BUCKET - 64'd1) / BUCKET;
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

   // Table access issued by the controller.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [30:0]       wr_data;
   } spmr_ram_req_type;

   // Table slot picked by a value: exact quotient by the bucket width, clamped to the last entry.
   function automatic logic [ADDR_W-1:0] slot_of(input logic [30:0] pick);
      logic [62:0] prod;
      logic [62:0] quot;
      prod = {32'd0, pick} * {31'd0, RECIP};
      quot = prod >> RECIP_SHIFT;
      if (quot >= 63'(TABLE_DEPTH)) begin
         slot_of = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         slot_of = quot[ADDR_W-1:0];
      end
   endfunction

endpackage

### hw/rtl/spmr_table.sv
// Shuffle table memory with one registered read port and one write port.
module spmr_table (
   input  logic                         clock,
   input  spmr_pkg::spmr_ram_req_type   ram_req,
   output logic [30:0]                  rd_data
);
   import spmr_pkg::*;

   logic [30:0] mem [TABLE_DEPTH];
   logic [30:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/spmr_mulmod.sv
// Multiply by 16807 and reduce modulo 2^31-1, with a register between the two steps.
module spmr_mulmod (
   input  logic        clock,
   input  logic        mul_en,
   input  logic [30:0] operand,
   output logic [30:0] result
);
   import spmr_pkg::*;

   logic [45:0] mul_ff;
   logic [45:0] mul_in;
   logic [31:0] sum;

   // Product stage.
   assign mul_in = {15'd0, operand} * {31'd0, MULTIPLIER};

   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_ff <= mul_in;
      end
   end

   // Fold the high part onto the low part; one subtraction brings it below the modulus.
   assign sum = {17'd0, mul_ff[45:31]} + {1'b0, mul_ff[30:0]};

   always_comb begin
      if (sum >= {1'b0, MODULUS}) begin
         result = 31'(sum - {1'b0, MODULUS});
      end else begin
         result = sum[30:0];
      end
   end

endmodule

### hw/rtl/shuffled_park_miller_rng.sv
// A draw on a seeded generator issues its table read and its multiply as the request is taken; the
// DRAW_FOLD state then writes the result into the output register once the previous result is taken.
// A new request is taken only in IDLE, so each draw finishes its write-back before the next is accepted.
// A seeding draw (first request, reseed, or a zero last pick) first runs the 40 warm-up steps,
// each a SEED_MUL and a SEED_FOLD state, and then a DRAW_ISSUE state to issue the table read.
// The output register lets the next request be taken while a result waits.
// Reset is synchronous: the generator is marked unseeded and the seed register reads -1.
// The shuffle table needs no clearing; seeding always fills it before it is read.
module shuffled_park_miller_rng (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,    // seed_value (signed)
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // [0] reseed, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata       // [30:0] sample, [31] zero
);
   import spmr_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SEED_MUL,
      SEED_FOLD,
      DRAW_ISSUE,
      DRAW_FOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [31:0]           seed_ff, seed_in;
   logic [30:0]           gen_ff, gen_in;
   logic [SEED_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic                  seeded_ff, seeded_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [30:0]           sample_ff, sample_in;

   spmr_ram_req_type      ram_req;
   logic [30:0]           rd_data;
   logic                  mul_en;
   logic [30:0]           mul_result;
   logic                  req_accept;
   logic                  rsp_free;
   logic [31:0]           seed_neg;
   logic [30:0]           start_value;

   spmr_table u_table (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   spmr_mulmod u_mulmod (
      .clock   (clock),
      .mul_en  (mul_en),
      .operand (gen_ff),
      .result  (mul_result)
   );

   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, sample_ff};

   // Start state: the negated seed, saturated at the modulus, or 1 for a non-negative seed.
   assign seed_neg = 32'd0 - seed_ff;
   always_comb begin
      if (seed_ff[31]) begin
         start_value = (seed_neg > {1'b0, MODULUS}) ? MODULUS : seed_neg[30:0];
      end else begin
         start_value = 31'd1;
      end
   end

   // Sequencer: seeding walk over the table, then the read, advance and write-back of a draw.
   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      gen_in       = gen_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sample_in    = sample_ff;
      mul_en       = 1'b0;
      ram_req      = '0;

      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               if (req_tdata[0] || !seeded_ff) begin
                  gen_in   = start_value;
                  cnt_in   = SEED_CNT_W'(SEED_STEPS - 1);
                  state_in = SEED_MUL;
               end else begin
                  mul_en          = 1'b1;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = slot_ff;
                  state_in        = DRAW_FOLD;
               end
            end
         end
         SEED_MUL: begin
            mul_en   = 1'b1;
            state_in = SEED_FOLD;
         end
         SEED_FOLD: begin
            gen_in = mul_result;
            // The last steps of the walk fill the table from the top entry down.
            if (cnt_ff < SEED_CNT_W'(TABLE_DEPTH)) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = cnt_ff[ADDR_W-1:0];
               ram_req.wr_data = mul_result;
            end
            if (cnt_ff == '0) begin
               slot_in  = slot_of(mul_result);
               state_in = DRAW_ISSUE;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = SEED_MUL;
            end
         end
         DRAW_ISSUE: begin
            mul_en          = 1'b1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = slot_ff;
            state_in        = DRAW_FOLD;
         end
         DRAW_FOLD: begin
            // Wait here while the previous result still sits in the output register.
            if (rsp_free) begin
               gen_in          = mul_result;
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = slot_ff;
               ram_req.wr_data = mul_result;
               sample_in       = (rd_data > CLAMP_MAX) ? CLAMP_MAX : rd_data;
               rsp_valid_in    = 1'b1;
               seeded_in       = (rd_data != 31'd0);
               slot_in         = slot_of(rd_data);
               state_in        = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         seed_ff      <= SEED_RESET;
         gen_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff    <= cnt_in;
      slot_ff   <= slot_in;
      sample_ff <= sample_in;
   end

   // A new result appears only at the end of a draw's write-back.
   a_result_from_draw : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == DRAW_FOLD)
      else $error("result raised outside a draw write-back");

   // Delivered samples never exceed the clamp value.
   a_sample_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> sample_ff <= CLAMP_MAX)
      else $error("sample above clamp value");

   // A request on an unseeded generator always starts the seeding walk.
   a_unseeded_seeds : assert property (@(posedge clock) disable iff (reset)
      req_accept && !seeded_ff |=> state_ff == SEED_MUL && cnt_ff == SEED_CNT_W'(SEED_STEPS - 1))
      else $error("unseeded request did not start seeding");

   // A draw writes back to the same slot that it read, where no stall came between the read and the write-back.
   a_writeback_slot : assert property (@(posedge clock) disable iff (reset)
      state_ff == DRAW_FOLD && $past(ram_req.rd_en) && ram_req.wr_en
      |-> ram_req.wr_addr == $past(ram_req.rd_addr))
      else $error("write-back slot differs from read slot");

endmodule

### sim/tb.sv
// Self-checking testbench of the shuffled minimal-standard generator: directed seeds, then random draws.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spmr_pkg::*;

   // Inverse of the multiplier modulo 2^31-1, used to aim a seed at a chosen warm-up value.
   localparam logic [30:0] MULT_INVERSE = 31'd1407677000;
   localparam int STALL_LIMIT = 2000;
   localparam int RESEED_PCT = 4;
   localparam int IDLE_PCT = 35;
   localparam int MAX_REPORTS = 10;

   // Tracks the generator and its shuffle table, and holds the samples still owed by the block.
   class draw_scoreboard;
      logic [31:0] seed_reg;
      logic [30:0] mcg_state;
      logic [30:0] shuffle [TABLE_DEPTH];
      logic [30:0] prev_pick;
      logic [30:0] owed_samples [$];
      int          errors;

      function new();
         seed_reg  = SEED_RESET;
         mcg_state = '0;
         prev_pick = '0;
         errors    = 0;
         foreach (shuffle[i]) shuffle[i] = '0;
      endfunction

      static function logic [30:0] mul_mod(input logic [30:0] a, input logic [30:0] b);
         longint unsigned p;
         p = 64'(a) * 64'(b);
         return 31'(p % 64'(MODULUS));
      endfunction

      // Restart from the seed register and run the warm-up; the last steps fill the table top down.
      function void seed_shuffle();
         logic [31:0] neg;
         int n;
         if (seed_reg[31]) begin
            neg = -seed_reg;
            mcg_state = (neg > 32'(MODULUS)) ? MODULUS : neg[30:0];
         end else begin
            mcg_state = 31'd1;
         end
         for (n = int'(SEED_STEPS) - 1; n >= 0; n--) begin
            mcg_state = mul_mod(mcg_state, 31'(MULTIPLIER));
            if (n < int'(TABLE_DEPTH)) shuffle[n] = mcg_state;
         end
         prev_pick = shuffle[0];
      endfunction

      // One draw: the previous pick selects a slot, whose entry is swapped for the new state.
      function logic [30:0] draw(input logic reseed);
         longint unsigned slot;
         logic [30:0] pick;
         if (reseed || prev_pick == '0) seed_shuffle();
         mcg_state = mul_mod(mcg_state, 31'(MULTIPLIER));
         slot = 64'(prev_pick) / BUCKET;
         if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
         pick = shuffle[slot];
         shuffle[slot] = mcg_state;
         prev_pick = pick;
         return (pick > CLAMP_MAX) ? CLAMP_MAX : pick;
      endfunction

      function void note_draw(input logic reseed);
         owed_samples.push_back(draw(reseed));
      endfunction

      function void check_sample(input logic [30:0] actual);
         logic [30:0] want;
         if (owed_samples.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: sample %0d arrived with no draw outstanding", actual);
         end else begin
            want = owed_samples.pop_front();
            if (actual !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR: sample expected %0d, got %0d", want, actual);
            end
         end
      endfunction

      function int pending();
         return owed_samples.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;      // [0] reseed, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;      // [30:0] sample, [31] zero
   bit          steady;
   int          stall_cycles;
   draw_scoreboard sb = new();

   shuffled_park_miller_rng dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: stall at random unless the steady stretch is running.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Check every result transaction against the oldest owed sample.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata[30:0]);
   end

   // Give up after too many cycles without any transaction.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Search for a seed whose first draw is above the clamp, so the clamp is exercised.
   function automatic logic [31:0] find_clamp_seed();
      draw_scoreboard probe;
      logic [30:0] target;
      logic [30:0] start;
      int step;
      probe = new();
      for (target = MODULUS - 31'd1; target > CLAMP_MAX; target--) begin
         start = target;
         for (step = 1; step <= int'(SEED_STEPS); step++) begin
            // Start value whose warm-up reaches the target after this many steps.
            start = draw_scoreboard::mul_mod(start, MULT_INVERSE);
            probe.seed_reg = -{1'b0, start};
            probe.prev_pick = '0;
            if (probe.draw(1'b0) == CLAMP_MAX) return -{1'b0, start};
         end
      end
      return SEED_RESET;
   endfunction

   // Offer one request transaction, idling first at random, and note it once accepted.
   task automatic send_draw(input logic reseed);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, reseed};
      do @(posedge clock); while (!req_tready);
      sb.note_draw(reseed);
   endtask

   task automatic run_draws(input int count, input int reseed_pct);
      int k;
      for (k = 0; k < count; k++) send_draw($urandom_range(0, 99) < reseed_pct);
   endtask

   // Stop sending and wait until every owed sample has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // The seed register is only written while the block is idle.
   task automatic load_seed(input logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.seed_reg = value;
   endtask

   initial begin
      logic [31:0] rnd_seed;
      int phase;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      steady = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset seed: the first draw seeds on its own, then a plain draw and a forced reseed.
      send_draw(1'b0);
      send_draw(1'b0);
      send_draw(1'b1);
      send_draw(1'b0);
      // Most negative seed saturates and collapses the generator to zero.
      load_seed(32'h8000_0000);
      send_draw(1'b0);
      send_draw(1'b1);
      // Seed equal to minus the modulus collapses the same way; zero picks keep reseeding.
      load_seed(32'h8000_0001);
      send_draw(1'b0);
      send_draw(1'b0);
      // Positive seeds, largest and zero, all start from one.
      load_seed(32'h7FFF_FFFF);
      send_draw(1'b0);
      send_draw(1'b1);
      load_seed(32'h0000_0000);
      send_draw(1'b1);
      send_draw(1'b0);
      // Small and large start values.
      load_seed(32'hFFFF_FFFE);
      send_draw(1'b1);
      send_draw(1'b0);
      send_draw(1'b0);
      load_seed(32'h8000_0002);
      send_draw(1'b1);
      send_draw(1'b0);
      // A seed whose first sample is clamped.
      load_seed(find_clamp_seed());
      send_draw(1'b1);
      send_draw(1'b0);

      // Random phases, each with its own seed; one phase runs without idling on either side.
      for (phase = 0; phase < 7; phase++) begin
         rnd_seed = $urandom;
         load_seed(rnd_seed);
         steady = (phase == 3);
         run_draws(100, RESEED_PCT);
         steady = 1'b0;
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

### shuffled_park_miller_rng.f
hw/rtl/spmr_pkg.sv
hw/rtl/spmr_table.sv
hw/rtl/spmr_mulmod.sv
hw/rtl/shuffled_park_miller_rng.sv
sim/tb.sv
